FILE: rtl/llt_pkg.sv
// Shared types for the lock log table: item kinds and controller states.
`default_nettype none

package llt_pkg;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_MERGE  = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND,
        ST_CLEAR,
        ST_NONE
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/lock_log_table.sv
// Lock log table: fill-ordered entry store with append, merge, lookup and clear.
// Append and clear strobe from their own state; on an empty table merge appends.
// Merge scans oldest first, lookup newest first; a match or a lookup miss gives the strobe.
// An empty lookup misses without a scan; a merge that misses every entry appends.
// busy falls in the strobe cycle, so the next beat can start there; results cannot stall.
// Reset clears state, fill count and control flags; memory has no reset value or sweep.
`default_nettype none

module lock_log_table #(
    parameter int CAPACITY   = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_lock_address,
    input  wire logic [15:0] i_lock_index,
    input  wire logic [1:0]  i_access_flags,
    output logic             o_strobe,
    output logic             o_hit,
    output logic [1:0]       o_flags_out,
    output logic [5:0]       o_slot,
    output logic [6:0]       o_fill_count,
    output logic             o_status
);

    localparam int KEY_W = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam int PW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int SW    = (PW > 6) ? PW : 6;
    localparam int FW    = (CW > 7) ? CW : 7;

    typedef struct packed {
        logic [KEY_W-1:0] addr;
        logic [15:0]      idx;
        logic [1:0]       rw;
    } t_entry;

    t_entry r_mem [CAPACITY];
    t_entry r_rd_data;

    llt_pkg::t_state r_state, n_state;

    logic [KEY_W-1:0] r_addr, n_addr;
    logic [15:0]      r_idx, n_idx;
    logic [1:0]       r_flags, n_flags;
    logic             r_merge, n_merge;
    logic [CW-1:0]    r_count, n_count;
    logic [PW-1:0]    r_ptr, n_ptr;
    logic             r_issue_done, n_issue_done;
    logic             r_rd_vld, n_rd_vld;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic             r_rd_last, n_rd_last;

    logic             r_strobe, n_strobe;
    logic             r_hit, n_hit;
    logic [1:0]       r_flags_out, n_flags_out;
    logic [PW-1:0]    r_slot, n_slot;
    logic [CW-1:0]    r_fill, n_fill;
    logic             r_status, n_status;

    logic             accept;
    logic             full;
    logic             match;
    logic             end_miss;
    logic             rd_en;
    logic             last_issue;
    logic             mem_we;
    logic [PW-1:0]    mem_wa;
    t_entry           mem_wd;
    logic [SW-1:0]    slot_ext;
    logic [FW-1:0]    fill_ext;

    assign busy     = (r_state != llt_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign full     = (r_count == CW'(CAPACITY));
    assign match    = r_rd_vld && (r_rd_data.addr == r_addr) && (r_rd_data.idx == r_idx);
    assign end_miss = r_rd_vld && r_rd_last && !match;
    assign last_issue = r_merge ? (r_ptr == PW'(r_count - 1'b1)) : (r_ptr == '0);
    assign rd_en    = (r_state == llt_pkg::ST_SCAN) && !r_issue_done && !match && !end_miss;

    always_comb begin
        n_state = r_state;
        case (r_state)
            llt_pkg::ST_IDLE: begin
                if (accept) begin
                    case (llt_pkg::t_kind'(i_kind))
                        llt_pkg::KIND_APPEND: n_state = llt_pkg::ST_APPEND;
                        llt_pkg::KIND_MERGE: begin
                            n_state = (r_count == '0) ? llt_pkg::ST_APPEND : llt_pkg::ST_SCAN;
                        end
                        llt_pkg::KIND_LOOKUP: begin
                            n_state = (r_count == '0) ? llt_pkg::ST_NONE : llt_pkg::ST_SCAN;
                        end
                        llt_pkg::KIND_CLEAR: n_state = llt_pkg::ST_CLEAR;
                        default: n_state = llt_pkg::ST_IDLE;
                    endcase
                end
            end
            llt_pkg::ST_SCAN: begin
                if (match) begin
                    n_state = llt_pkg::ST_IDLE;
                end else if (end_miss) begin
                    n_state = r_merge ? llt_pkg::ST_APPEND : llt_pkg::ST_IDLE;
                end
            end
            llt_pkg::ST_APPEND: n_state = llt_pkg::ST_IDLE;
            llt_pkg::ST_CLEAR:  n_state = llt_pkg::ST_IDLE;
            llt_pkg::ST_NONE:   n_state = llt_pkg::ST_IDLE;
            default:            n_state = llt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_addr       = r_addr;
        n_idx        = r_idx;
        n_flags      = r_flags;
        n_merge      = r_merge;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_issue_done = r_issue_done;
        n_rd_vld     = rd_en;
        n_rd_ptr     = r_ptr;
        n_rd_last    = last_issue;
        n_strobe     = 1'b0;
        n_hit        = 1'b0;
        n_flags_out  = 2'b00;
        n_slot       = '0;
        n_fill       = r_count;
        n_status     = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = r_count[PW-1:0];
        mem_wd       = '{addr: r_addr, idx: r_idx, rw: r_flags};

        case (r_state)
            llt_pkg::ST_IDLE: begin
                if (accept) begin
                    n_addr       = i_lock_address[KEY_W-1:0];
                    n_idx        = i_lock_index;
                    n_flags      = i_access_flags;
                    n_merge      = (llt_pkg::t_kind'(i_kind) == llt_pkg::KIND_MERGE);
                    n_ptr        = n_merge ? '0 : PW'(r_count - 1'b1);
                    n_issue_done = 1'b0;
                end
            end
            llt_pkg::ST_SCAN: begin
                if (rd_en) begin
                    n_ptr = r_merge ? (r_ptr + 1'b1) : (r_ptr - 1'b1);
                    if (last_issue) begin
                        n_issue_done = 1'b1;
                    end
                end
                if (match) begin
                    n_strobe    = 1'b1;
                    n_hit       = 1'b1;
                    n_slot      = r_rd_ptr;
                    n_flags_out = r_merge ? (r_rd_data.rw | r_flags) : r_rd_data.rw;
                    if (r_merge) begin
                        mem_we = 1'b1;
                        mem_wa = r_rd_ptr;
                        mem_wd = '{addr: r_rd_data.addr, idx: r_rd_data.idx,
                                   rw: r_rd_data.rw | r_flags};
                    end
                end else if (end_miss && !r_merge) begin
                    n_strobe = 1'b1;
                end
            end
            llt_pkg::ST_APPEND: begin
                n_strobe = 1'b1;
                if (full) begin
                    n_status = 1'b1;
                end else begin
                    mem_we      = 1'b1;
                    n_count     = r_count + 1'b1;
                    n_fill      = r_count + 1'b1;
                    n_flags_out = r_flags;
                    n_slot      = r_count[PW-1:0];
                end
            end
            llt_pkg::ST_CLEAR: begin
                n_strobe = 1'b1;
                n_count  = '0;
                n_fill   = '0;
            end
            llt_pkg::ST_NONE: begin
                n_strobe = 1'b1;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= llt_pkg::ST_IDLE;
            r_count      <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_issue_done <= n_issue_done;
            r_rd_vld     <= n_rd_vld;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_idx       <= n_idx;
        r_flags     <= n_flags;
        r_merge     <= n_merge;
        r_ptr       <= n_ptr;
        r_rd_ptr    <= n_rd_ptr;
        r_rd_last   <= n_rd_last;
        r_hit       <= n_hit;
        r_flags_out <= n_flags_out;
        r_slot      <= n_slot;
        r_fill      <= n_fill;
        r_status    <= n_status;
    end

    assign slot_ext     = SW'(r_slot);
    assign fill_ext     = FW'(r_fill);
    assign o_strobe     = r_strobe;
    assign o_hit        = r_hit;
    assign o_flags_out  = r_flags_out;
    assign o_slot       = slot_ext[5:0];
    assign o_fill_count = fill_ext[6:0];
    assign o_status     = r_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> $past(busy))
        else $error("result beat without an item in progress");

    a_write_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == llt_pkg::ST_SCAN || r_state == llt_pkg::ST_APPEND))
        else $error("entry write outside merge or append");

    a_drop_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status) |-> (!o_hit && o_flags_out == 2'b00))
        else $error("dropped append reports a hit");
`endif

endmodule

`default_nettype wire

FILE: test/lock_log_table_chk.sv
// Checker for lock_log_table: predicts each beat's result and compares the strobed outputs.
`timescale 1ns / 100ps

module lock_log_table_chk #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_lock_address,
    input  logic [15:0] i_lock_index,
    input  logic [1:0]  i_access_flags,
    input  logic        o_strobe,
    input  logic        o_hit,
    input  logic [1:0]  o_flags_out,
    input  logic [5:0]  o_slot,
    input  logic [6:0]  o_fill_count,
    input  logic        o_status,
    output int          errors,
    output int          pending,
    output int          n_results,
    output int          n_hits,
    output int          n_drops,
    output int          n_clears
);

    typedef struct packed {
        logic       hit;
        logic [1:0] flags;
        logic [5:0] slot;
        logic [6:0] fill;
        logic       status;
    } t_lock_result;

    logic [31:0]  log_addr  [CAPACITY];
    logic [15:0]  log_index [CAPACITY];
    logic [1:0]   log_flags [CAPACITY];
    int unsigned  log_fill;

    t_lock_result result_q[$];
    t_lock_result want;
    t_lock_result got;

    initial begin
        errors    = 0;
        pending   = 0;
        n_results = 0;
        n_hits    = 0;
        n_drops   = 0;
        n_clears  = 0;
        log_fill  = 0;
    end

    function automatic t_lock_result log_append(logic [31:0] addr, logic [15:0] index,
                                                logic [1:0] flags);
        t_lock_result r;
        r = '0;
        if (log_fill >= CAPACITY) begin
            r.fill   = 7'(log_fill);
            r.status = 1'b1;
            return r;
        end
        log_addr[log_fill]  = addr;
        log_index[log_fill] = index;
        log_flags[log_fill] = flags;
        r.flags = flags;
        r.slot  = 6'(log_fill);
        log_fill = log_fill + 1;
        r.fill  = 7'(log_fill);
        return r;
    endfunction

    function automatic t_lock_result lock_table_op(llt_pkg::t_kind kind, logic [31:0] addr,
                                                   logic [15:0] index, logic [1:0] flags);
        t_lock_result r;
        r = '0;
        case (kind)
            llt_pkg::KIND_APPEND: begin
                r = log_append(addr, index, flags);
            end
            llt_pkg::KIND_MERGE: begin
                for (int i = 0; i < int'(log_fill); i++) begin
                    if (log_addr[i] == addr && log_index[i] == index) begin
                        log_flags[i] = log_flags[i] | flags;
                        r.hit   = 1'b1;
                        r.flags = log_flags[i];
                        r.slot  = 6'(i);
                        r.fill  = 7'(log_fill);
                        return r;
                    end
                end
                r = log_append(addr, index, flags);
            end
            llt_pkg::KIND_LOOKUP: begin
                r.fill = 7'(log_fill);
                for (int i = int'(log_fill) - 1; i >= 0; i--) begin
                    if (log_addr[i] == addr && log_index[i] == index) begin
                        r.hit   = 1'b1;
                        r.flags = log_flags[i];
                        r.slot  = 6'(i);
                        return r;
                    end
                end
            end
            default: begin
                log_fill = 0;
            end
        endcase
        return r;
    endfunction

    function automatic void report_mismatch(string what, t_lock_result e, t_lock_result a);
        errors = errors + 1;
        if (errors <= 10) begin
            $display("%0t: %s exp hit=%0b flags=%0d slot=%0d fill=%0d status=%0b",
                     $realtime, what, e.hit, e.flags, e.slot, e.fill, e.status);
            $display("    act hit=%0b flags=%0d slot=%0d fill=%0d status=%0b",
                     a.hit, a.flags, a.slot, a.fill, a.status);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            log_fill = 0;
            result_q.delete();
        end else begin
            if (o_strobe) begin
                got = {o_hit, o_flags_out, o_slot, o_fill_count, o_status};
                n_results = n_results + 1;
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected result", '0, got);
                end else begin
                    want = result_q.pop_front();
                    if (want.hit !== got.hit || want.flags !== got.flags ||
                        want.slot !== got.slot || want.fill !== got.fill ||
                        want.status !== got.status)
                        report_mismatch("result mismatch", want, got);
                end
            end
            if (start && !busy) begin
                want = lock_table_op(llt_pkg::t_kind'(i_kind), i_lock_address, i_lock_index,
                                     i_access_flags);
                if (want.hit) n_hits = n_hits + 1;
                if (want.status) n_drops = n_drops + 1;
                if (llt_pkg::t_kind'(i_kind) == llt_pkg::KIND_CLEAR) n_clears = n_clears + 1;
                result_q.push_back(want);
            end
        end
        pending = result_q.size();
    end

endmodule

FILE: test/lock_log_table_tb.sv
// Testbench top for lock_log_table: clock, reset, beat stimulus and the verdict.
`timescale 1ns / 100ps

module lock_log_table_tb;

    localparam int CAPACITY   = 64;
    localparam int CYCLE_CAP  = 1_000_000;
    localparam int PHASE_BEATS = 620;

    localparam logic [1:0] FLAG_NONE  = 2'b00;
    localparam logic [1:0] FLAG_READ  = 2'b01;
    localparam logic [1:0] FLAG_WRITE = 2'b10;
    localparam logic [1:0] FLAG_BOTH  = 2'b11;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_kind = llt_pkg::KIND_APPEND;
    logic [31:0] i_lock_address = '0;
    logic [15:0] i_lock_index = '0;
    logic [1:0]  i_access_flags = FLAG_NONE;
    logic        o_strobe;
    logic        o_hit;
    logic [1:0]  o_flags_out;
    logic [5:0]  o_slot;
    logic [6:0]  o_fill_count;
    logic        o_status;

    int errors, pending, n_results, n_hits, n_drops, n_clears;
    int cycles = 0;
    int idle_pct = 22;
    int clear_permille = 10;

    logic [31:0] pool_addr [8];
    logic [15:0] pool_index [8];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    lock_log_table #(
        .CAPACITY   (CAPACITY),
        .ADDR_WIDTH (32)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_lock_address (i_lock_address),
        .i_lock_index   (i_lock_index),
        .i_access_flags (i_access_flags),
        .o_strobe       (o_strobe),
        .o_hit          (o_hit),
        .o_flags_out    (o_flags_out),
        .o_slot         (o_slot),
        .o_fill_count   (o_fill_count),
        .o_status       (o_status)
    );

    lock_log_table_chk #(
        .CAPACITY (CAPACITY)
    ) u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_lock_address (i_lock_address),
        .i_lock_index   (i_lock_index),
        .i_access_flags (i_access_flags),
        .o_strobe       (o_strobe),
        .o_hit          (o_hit),
        .o_flags_out    (o_flags_out),
        .o_slot         (o_slot),
        .o_fill_count   (o_fill_count),
        .o_status       (o_status),
        .errors         (errors),
        .pending        (pending),
        .n_results      (n_results),
        .n_hits         (n_hits),
        .n_drops        (n_drops),
        .n_clears       (n_clears)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("lock_log_table test failed");
            $finish;
        end
    end

    // optional sender gap, then hold the beat until busy is low at an edge
    task automatic send_beat(llt_pkg::t_kind kind, logic [31:0] addr, logic [15:0] index,
                             logic [1:0] flags);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_kind         <= kind;
        i_lock_address <= addr;
        i_lock_index   <= index;
        i_access_flags <= flags;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_pool_or_random(llt_pkg::t_kind kind, int pool_pct);
        int k;
        k = $urandom_range(0, 7);
        if ($urandom_range(0, 99) < pool_pct)
            send_beat(kind, pool_addr[k], pool_index[k], 2'($urandom_range(0, 3)));
        else
            send_beat(kind, $urandom, 16'($urandom), 2'($urandom_range(0, 3)));
    endtask

    task automatic random_phase(int beats);
        int r;
        for (int n = 0; n < beats; n++) begin
            if (n % 150 == 0)
                clear_permille = ($urandom_range(0, 1) != 0) ? 80 : 4;
            r = $urandom_range(0, 999);
            if (r < clear_permille)
                send_beat(llt_pkg::KIND_CLEAR, $urandom, 16'($urandom),
                          2'($urandom_range(0, 3)));
            else if (r < 300)
                send_pool_or_random(llt_pkg::KIND_APPEND, 70);
            else if (r < 650)
                send_pool_or_random(llt_pkg::KIND_MERGE, 75);
            else
                send_pool_or_random(llt_pkg::KIND_LOOKUP, 85);
        end
    endtask

    initial begin
        logic [31:0] key_a;
        logic [15:0] idx_a;
        for (int k = 0; k < 8; k++) begin
            pool_addr[k]  = $urandom;
            pool_index[k] = 16'($urandom);
        end
        pool_addr[1]  = pool_addr[0];
        pool_index[3] = pool_index[2];
        key_a = pool_addr[0];
        idx_a = pool_index[0];

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, duplicates, partial key matches, clear
        send_beat(llt_pkg::KIND_LOOKUP, key_a, idx_a, FLAG_BOTH);
        send_beat(llt_pkg::KIND_APPEND, 32'h0000_0000, 16'h0000, FLAG_NONE);
        send_beat(llt_pkg::KIND_APPEND, 32'hFFFF_FFFF, 16'hFFFF, FLAG_BOTH);
        send_beat(llt_pkg::KIND_APPEND, key_a, idx_a, FLAG_READ);
        send_beat(llt_pkg::KIND_APPEND, key_a, idx_a, FLAG_WRITE);
        send_beat(llt_pkg::KIND_MERGE, key_a, idx_a, FLAG_WRITE);
        send_beat(llt_pkg::KIND_LOOKUP, key_a, idx_a, FLAG_NONE);
        send_beat(llt_pkg::KIND_MERGE, key_a, pool_index[1], FLAG_READ);
        send_beat(llt_pkg::KIND_MERGE, pool_addr[2], pool_index[3], FLAG_NONE);
        send_beat(llt_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, FLAG_NONE);
        send_beat(llt_pkg::KIND_MERGE, 32'h0000_0000, 16'h0000, FLAG_BOTH);
        send_beat(llt_pkg::KIND_LOOKUP, 32'h0000_0000, 16'h0000, FLAG_READ);
        send_beat(llt_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, FLAG_BOTH);
        send_beat(llt_pkg::KIND_LOOKUP, key_a, idx_a, FLAG_NONE);
        send_beat(llt_pkg::KIND_MERGE, key_a, idx_a, FLAG_READ);
        send_beat(llt_pkg::KIND_LOOKUP, key_a, idx_a, FLAG_NONE);
        send_beat(llt_pkg::KIND_CLEAR, 32'h0000_0000, 16'h0000, FLAG_NONE);

        // fill to capacity, then drop two appends and a missing merge
        for (int n = 0; n < CAPACITY + 2; n++)
            send_pool_or_random(llt_pkg::KIND_APPEND, 60);
        send_beat(llt_pkg::KIND_MERGE, $urandom, 16'($urandom), FLAG_BOTH);
        send_pool_or_random(llt_pkg::KIND_MERGE, 100);
        send_pool_or_random(llt_pkg::KIND_LOOKUP, 100);
        send_beat(llt_pkg::KIND_CLEAR, $urandom, 16'($urandom), FLAG_NONE);

        idle_pct = 22;
        random_phase(PHASE_BEATS);
        idle_pct = 62;
        random_phase(PHASE_BEATS);
        idle_pct = 0;
        random_phase(PHASE_BEATS);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);

        $display("checked %0d results in %0d cycles: %0d hits, %0d dropped on full table",
                 n_results, cycles, n_hits, n_drops);
        $display("%0d clears, %0d mismatches", n_clears, errors);
        if (errors == 0 && pending == 0)
            $display("lock_log_table test passed");
        else
            $display("lock_log_table test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/llt_pkg.sv
rtl/lock_log_table.sv
test/lock_log_table_chk.sv
test/lock_log_table_tb.sv
